@@ src/dhqp_pkg.sv @@
package dhqp_pkg;

    localparam int DEFAULT_MAX_NAME_BYTES = 256;
    localparam int DEFAULT_QUEUE_DEPTH    = 4;

    localparam int HDR_WORDS          = 5;
    localparam logic [3:0] HDR_LAST_IDX  = 4'd11;
    localparam logic [3:0] HDR_WORD_LIMIT = 4'd10;
    localparam int FLAG_Z_BIT         = 6;
    localparam logic [7:0] DOT_CHAR   = 8'h2E;
    localparam logic [1:0] TAIL_LAST_IDX = 2'd3;

    localparam int OUT_TDATA_W = 136;
    localparam int IN_TDATA_W  = 8;

    // header word slots
    localparam logic [2:0] W_ID    = 3'd0;
    localparam logic [2:0] W_FLAGS = 3'd1;
    localparam logic [2:0] W_QD    = 3'd2;
    localparam logic [2:0] W_AN    = 3'd3;
    localparam logic [2:0] W_NS    = 3'd4;

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_CHAR   = 2'd1,
        KIND_COMMIT = 2'd2,
        KIND_DROP   = 2'd3
    } kind_t;

    typedef enum logic [4:0] {
        PH_HEADER     = 5'b00001,
        PH_NAME_START = 5'b00010,
        PH_NAME       = 5'b00100,
        PH_TAIL       = 5'b01000,
        PH_SKIP       = 5'b10000
    } phase_t;

    typedef struct packed {
        kind_t       kind;
        logic [15:0] query_class;
        logic [15:0] query_type;
        logic [7:0]  name_char;
        logic [15:0] additional_count;
        logic [15:0] ns_count;
        logic [15:0] an_count;
        logic [15:0] question_count;
        logic [3:0]  rcode_value;
        logic [3:0]  opcode_value;
        logic        qr_flag;
        logic [15:0] msg_id;
    } record_t;

    // one parsed byte's output: a record, optionally followed by a drop record
    typedef struct packed {
        record_t rec;
        logic    drop_after;
    } event_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ src/dhqp_front.sv @@
module dhqp_front #(
    parameter int MAX_NAME_BYTES = dhqp_pkg::DEFAULT_MAX_NAME_BYTES
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             accept,
    input  logic [7:0]       data_byte,
    input  logic             last_byte,
    output logic             ev_valid,
    output dhqp_pkg::event_t ev
);
    import dhqp_pkg::*;

    localparam int NC_W = $clog2(MAX_NAME_BYTES + 1);
    localparam logic [NC_W-1:0] NAME_LIMIT = NC_W'(MAX_NAME_BYTES);

    phase_t          phase_reg, phase_next;
    logic [3:0]      hidx_reg, hidx_next;
    logic [15:0]     hword_reg [HDR_WORDS];
    logic [7:0]      label_reg, label_next;
    logic [NC_W-1:0] ncount_reg, ncount_next;
    logic [15:0]     qdone_reg, qdone_next;
    logic [23:0]     shift_reg, shift_next;
    logic [1:0]      tidx_reg, tidx_next;

    logic            hword_we;
    logic [NC_W-1:0] ncount_inc;
    logic [15:0]     qdone_inc;
    logic [15:0]     flags;

    assign ncount_inc = ncount_reg + 1'b1;
    assign qdone_inc  = qdone_reg + 16'd1;
    assign flags      = hword_reg[W_FLAGS];

    always_comb
    begin
        phase_next  = phase_reg;
        hidx_next   = hidx_reg;
        label_next  = label_reg;
        ncount_next = ncount_reg;
        qdone_next  = qdone_reg;
        shift_next  = shift_reg;
        tidx_next   = tidx_reg;
        hword_we    = 1'b0;
        ev_valid    = 1'b0;
        ev          = '0;

        case (phase_reg)
            PH_HEADER:
            begin
                if (!hidx_reg[0])
                begin
                    shift_next = {16'd0, data_byte};
                end
                else if (hidx_reg < HDR_WORD_LIMIT)
                begin
                    hword_we = 1'b1;
                end
                if (hidx_reg >= HDR_LAST_IDX)
                begin
                    shift_next = '0;
                    if (flags[FLAG_Z_BIT])
                    begin
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        ev_valid                  = 1'b1;
                        ev.rec.kind               = KIND_HEADER;
                        ev.rec.msg_id             = hword_reg[W_ID];
                        ev.rec.qr_flag            = flags[15];
                        ev.rec.opcode_value       = flags[14:11];
                        ev.rec.rcode_value        = flags[3:0];
                        ev.rec.question_count     = hword_reg[W_QD];
                        ev.rec.an_count           = hword_reg[W_AN];
                        ev.rec.ns_count           = hword_reg[W_NS];
                        ev.rec.additional_count   = {shift_reg[7:0], data_byte};
                        if (hword_reg[W_QD] == 16'd0)
                        begin
                            phase_next = PH_SKIP;
                        end
                        else
                        begin
                            label_next  = '0;
                            ncount_next = '0;
                            tidx_next   = '0;
                            phase_next  = PH_NAME_START;
                        end
                    end
                end
                else
                begin
                    hidx_next = hidx_reg + 4'd1;
                end
            end
            PH_NAME_START, PH_NAME:
            begin
                if (data_byte == 8'd0)
                begin
                    phase_next = PH_TAIL;
                    tidx_next  = '0;
                    shift_next = '0;
                    if (last_byte)
                    begin
                        ev_valid    = 1'b1;
                        ev.rec.kind = KIND_DROP;
                    end
                end
                else
                begin
                    ncount_next = ncount_inc;
                    if (ncount_inc >= NAME_LIMIT)
                    begin
                        ev_valid    = 1'b1;
                        ev.rec.kind = KIND_DROP;
                        phase_next  = PH_SKIP;
                    end
                    else if (phase_reg == PH_NAME_START)
                    begin
                        label_next = data_byte;
                        phase_next = PH_NAME;
                        // leading length byte emits nothing, only a possible drop
                        if (last_byte)
                        begin
                            ev_valid    = 1'b1;
                            ev.rec.kind = KIND_DROP;
                        end
                    end
                    else
                    begin
                        ev_valid      = 1'b1;
                        ev.rec.kind   = KIND_CHAR;
                        ev.drop_after = last_byte;
                        if (label_reg == 8'd0)
                        begin
                            label_next       = data_byte;
                            ev.rec.name_char = DOT_CHAR;
                        end
                        else
                        begin
                            label_next       = label_reg - 8'd1;
                            ev.rec.name_char = data_byte;
                        end
                    end
                end
            end
            PH_TAIL:
            begin
                if (tidx_reg >= TAIL_LAST_IDX)
                begin
                    ev_valid           = 1'b1;
                    ev.rec.kind        = KIND_COMMIT;
                    ev.rec.query_type  = shift_reg[23:8];
                    ev.rec.query_class = {shift_reg[7:0], data_byte};
                    qdone_next         = qdone_inc;
                    if (qdone_inc >= hword_reg[W_QD])
                    begin
                        phase_next = PH_SKIP;
                    end
                    else
                    begin
                        label_next  = '0;
                        ncount_next = '0;
                        shift_next  = '0;
                        tidx_next   = '0;
                        phase_next  = PH_NAME_START;
                    end
                end
                else
                begin
                    shift_next = {shift_reg[15:0], data_byte};
                    tidx_next  = tidx_reg + 2'd1;
                    if (last_byte)
                    begin
                        ev_valid    = 1'b1;
                        ev.rec.kind = KIND_DROP;
                    end
                end
            end
            default:
            begin
            end
        endcase

        // end of message returns the parser to its idle state
        if (last_byte)
        begin
            phase_next  = PH_HEADER;
            hidx_next   = '0;
            label_next  = '0;
            ncount_next = '0;
            qdone_next  = '0;
            shift_next  = '0;
            tidx_next   = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_HEADER;
            hidx_reg   <= '0;
            label_reg  <= '0;
            ncount_reg <= '0;
            qdone_reg  <= '0;
            shift_reg  <= '0;
            tidx_reg   <= '0;
        end
        else if (accept)
        begin
            phase_reg  <= phase_next;
            hidx_reg   <= hidx_next;
            label_reg  <= label_next;
            ncount_reg <= ncount_next;
            qdone_reg  <= qdone_next;
            shift_reg  <= shift_next;
            tidx_reg   <= tidx_next;
        end
    end

    // header words are always written before they are read
    always_ff @(posedge clk)
    begin
        if (accept && hword_we)
        begin
            hword_reg[hidx_reg[3:1]] <= {shift_reg[7:0], data_byte};
        end
    end

endmodule

@@ src/dhqp_queue.sv @@
module dhqp_queue #(
    parameter int DEPTH = dhqp_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  dhqp_pkg::event_t    push_ev,
    input  logic                pop,
    output dhqp_pkg::event_t    pop_ev,
    output dhqp_pkg::q_status_t status
);
    import dhqp_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    event_t          slot_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign pop_ev       = slot_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_ev;
        end
    end

endmodule

@@ src/dhqp_back.sv @@
module dhqp_back (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 q_empty,
    input  dhqp_pkg::event_t                     q_ev,
    output logic                                 q_pop,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [dhqp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    output logic [1:0]                           m_tuser,
    output logic                                 drop_pending
);
    import dhqp_pkg::*;

    localparam int PAD_W = OUT_TDATA_W - ($bits(record_t) - $bits(kind_t));

    logic    out_valid_reg, out_valid_next;
    logic    pend_reg, pend_next;
    record_t rec_reg, rec_next;
    logic    load;

    assign load = !out_valid_reg || m_tready;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        pend_next      = pend_reg;
        rec_next       = rec_reg;
        q_pop          = 1'b0;
        if (load)
        begin
            if (pend_reg)
            begin
                // second record of a byte: the drop after its last character
                out_valid_next = 1'b1;
                pend_next      = 1'b0;
                rec_next       = '0;
                rec_next.kind  = KIND_DROP;
            end
            else if (!q_empty)
            begin
                q_pop          = 1'b1;
                out_valid_next = 1'b1;
                pend_next      = q_ev.drop_after;
                rec_next       = q_ev.rec;
            end
            else
            begin
                out_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pend_reg      <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            pend_reg      <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg <= rec_next;
    end

    assign m_tvalid     = out_valid_reg;
    assign m_tuser      = rec_reg.kind;
    assign drop_pending = pend_reg;
    assign m_tdata      = {{PAD_W{1'b0}},
                           rec_reg.query_class,
                           rec_reg.query_type,
                           rec_reg.name_char,
                           rec_reg.additional_count,
                           rec_reg.ns_count,
                           rec_reg.an_count,
                           rec_reg.question_count,
                           rec_reg.rcode_value,
                           rec_reg.opcode_value,
                           rec_reg.qr_flag,
                           rec_reg.msg_id};

endmodule

@@ src/dns_header_question_parser.sv @@
// channel  dir  signals                         content
// s_*      in   s_tvalid s_tready s_tdata s_tlast  message bytes, tlast on final byte
// m_*      out  m_tvalid m_tready m_tdata m_tuser  records, tuser holds the record kind
//
// one byte accepted per cycle while s_tready is high
// the front parser updates its field and counter state in the accepting cycle
// records pass a small queue into the output register; one per cycle unless stalled
// a name character on the final byte yields two records: the character, then a drop
// reset clears parser, queue and output register; no clearing pass is needed
// a stalled output fills the queue, then s_tready drops until a record is taken
module dns_header_question_parser #(
    parameter int MAX_NAME_BYTES = dhqp_pkg::DEFAULT_MAX_NAME_BYTES,
    parameter int QUEUE_DEPTH    = dhqp_pkg::DEFAULT_QUEUE_DEPTH
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             s_tvalid,
    output logic                             s_tready,
    input  logic [dhqp_pkg::IN_TDATA_W-1:0]  s_tdata,   // [7:0] data_byte
    input  logic                             s_tlast,   // last_byte
    output logic                             m_tvalid,
    input  logic                             m_tready,
    // [15:0] msg_id, [16] qr_flag, [20:17] opcode_value,
    // [24:21] rcode_value, [40:25] question_count, [56:41] an_count,
    // [72:57] ns_count, [88:73] additional_count, [96:89] name_char,
    // [112:97] query_type, [128:113] query_class, [135:129] zero
    output logic [dhqp_pkg::OUT_TDATA_W-1:0] m_tdata,
    output logic [1:0]                       m_tuser    // [1:0] kind
);
    import dhqp_pkg::*;

    logic      accept;
    logic      ev_valid;
    event_t    ev;
    event_t    q_ev;
    logic      q_pop;
    q_status_t q_status;
    logic      drop_pending;

    assign s_tready = !q_status.full;
    assign accept   = s_tvalid && s_tready;

    dhqp_front #(
        .MAX_NAME_BYTES(MAX_NAME_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .accept   (accept),
        .data_byte(s_tdata[7:0]),
        .last_byte(s_tlast),
        .ev_valid (ev_valid),
        .ev       (ev)
    );

    dhqp_queue #(
        .DEPTH(QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (accept && ev_valid),
        .push_ev(ev),
        .pop    (q_pop),
        .pop_ev (q_ev),
        .status (q_status)
    );

    dhqp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_empty     (q_status.empty),
        .q_ev        (q_ev),
        .q_pop       (q_pop),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tuser     (m_tuser),
        .drop_pending(drop_pending)
    );

`ifndef SYNTHESIS
    // a pending drop always sits behind a record in the output register
    a_pend_has_out: assert property (@(posedge clk) disable iff (!rst_n)
        drop_pending |-> m_tvalid)
        else $error("drop pending without an output record");

    // character records carry nothing but the character
    a_char_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser == KIND_CHAR) |->
            (m_tdata[88:0] == '0 && m_tdata[135:97] == '0))
        else $error("character record with stray field bits");

    // nothing left anywhere: output goes idle after the last record is taken
    a_drain_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && q_status.empty && !drop_pending) |=> !m_tvalid)
        else $error("record appeared from an empty back end");

    // the queue never pops when empty
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_status.empty)
        else $error("queue pop while empty");
`endif

endmodule
